/* hw/rtl/dofp_pkg.sv */
// Shared types, constants and codes for the framed DOF packet parser.
package dofp_pkg;

  localparam int DOF_COUNT       = 6;
  localparam int BYTES_PER_VALUE = 4;
  localparam int BUF_BYTES       = DOF_COUNT * BYTES_PER_VALUE;
  localparam int BUF_AW          = $clog2(BUF_BYTES);
  localparam int COUNT_W         = $clog2(BUF_BYTES + 1);
  localparam int SEL_W           = $clog2(BYTES_PER_VALUE);
  localparam int IDX_W           = 3;
  localparam int VALUE_W         = 32;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_FLOAT = 2'd1;

  localparam logic [1:0] REG_DATA_MODE    = 2'd0;
  localparam logic [1:0] REG_START_MARKER = 2'd1;
  localparam logic [1:0] REG_END_MARKER   = 2'd2;

  localparam logic [7:0] START_MARKER_RST = 8'd60;
  localparam logic [7:0] END_MARKER_RST   = 8'd62;

  // byte map: b*28/255 - 14 in Q15.16 = b*7196 + round(b*28/255) - 917504
  localparam logic [12:0] MAP_MUL    = 13'd7196;
  localparam logic [4:0]  MAP_FRAC   = 5'd28;
  localparam logic [12:0] MAP_RND    = 13'd127;
  localparam logic [8:0]  MAP_DIV    = 9'd255;
  localparam logic signed [VALUE_W-1:0] MAP_OFFSET = 32'sd917504;

  typedef enum logic [1:0] {
    S_RX,
    S_READ,
    S_TAKE,
    S_SEND
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [BUF_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [BUF_AW-1:0] rd_addr;
  } ram_req_t;

endpackage

/* hw/rtl/framed_dof_packet_parser.sv */
// Top level of the framed DOF packet parser: framing control, readout and output register.
//
// Accepts one serial byte per cycle while a frame is being received or searched for.
// The closing byte of an accepted byte- or float-mode frame starts a readout of the
// payload buffer through its single read port: each stored byte is read, then taken,
// and each value but the last waits in the output register until the receiver takes
// it. Input is held off for the whole readout, which a stalled non-final value lengthens.
// A command-mode frame gives its single result without readout. A closing byte waits
// while the previous result is still held in the output register.
module framed_dof_packet_parser (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [7:0]                             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             byte_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [dofp_pkg::IDX_W-1:0]             dof_index,
  output logic signed [dofp_pkg::VALUE_W-1:0]    dof_value,
  output logic                                   has_value,
  output logic                                   last
);

  dofp_pkg::state_t state, state_next;

  logic [1:0] data_mode;
  logic [7:0] start_marker;
  logic [7:0] end_marker;

  logic                             frame_open;
  logic [dofp_pkg::COUNT_W-1:0]     byte_count;
  logic [dofp_pkg::COUNT_W-1:0]     payload_len;
  logic                             closing;
  logic                             in_xfer;
  logic                             out_xfer;
  logic                             frame_ok;
  logic                             start_emit;
  logic                             load_cmd;
  logic                             load_val;
  logic                             val_done;
  logic                             val_last;

  logic                             emit_float;
  logic [dofp_pkg::BUF_AW-1:0]      rd_addr;
  logic [dofp_pkg::IDX_W-1:0]       val_idx;
  logic [dofp_pkg::SEL_W-1:0]       byte_sel;
  logic [dofp_pkg::VALUE_W-1:0]     word;

  dofp_pkg::ram_req_t               ram_req;
  logic [7:0]                       rd_data;
  logic signed [dofp_pkg::VALUE_W-1:0] mapped;

  dofp_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  dofp_map u_map (
    .byte_val (rd_data),
    .value    (mapped)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_mode    <= dofp_pkg::MODE_BYTE;
      start_marker <= dofp_pkg::START_MARKER_RST;
      end_marker   <= dofp_pkg::END_MARKER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dofp_pkg::REG_DATA_MODE:    data_mode    <= cfg_data[1:0];
        dofp_pkg::REG_START_MARKER: start_marker <= cfg_data;
        dofp_pkg::REG_END_MARKER:   end_marker   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (data_mode)
      dofp_pkg::MODE_BYTE:  payload_len = dofp_pkg::COUNT_W'(dofp_pkg::DOF_COUNT);
      dofp_pkg::MODE_FLOAT: payload_len = dofp_pkg::COUNT_W'(dofp_pkg::BUF_BYTES);
      default:              payload_len = '0;
    endcase
  end

  assign closing  = frame_open && (byte_count >= payload_len);
  assign in_ready = (state == dofp_pkg::S_RX) && !(closing && out_valid);
  assign out_xfer = out_valid && out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign frame_ok = in_xfer && closing && (byte_in == end_marker);
  assign val_done = !emit_float || (byte_sel == dofp_pkg::SEL_W'(dofp_pkg::BYTES_PER_VALUE - 1));
  assign val_last = (val_idx == dofp_pkg::IDX_W'(dofp_pkg::DOF_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dofp_pkg::S_RX;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    start_emit = 1'b0;
    load_cmd   = 1'b0;
    load_val   = 1'b0;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = byte_count[dofp_pkg::BUF_AW-1:0];
    ram_req.wr_data = byte_in;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = rd_addr;
    case (state)
      dofp_pkg::S_RX: begin
        ram_req.wr_en = in_xfer && frame_open && !closing;
        if (frame_ok) begin
          if (data_mode == dofp_pkg::MODE_BYTE || data_mode == dofp_pkg::MODE_FLOAT) begin
            start_emit = 1'b1;
            state_next = dofp_pkg::S_READ;
          end else begin
            load_cmd = 1'b1;
          end
        end
      end
      dofp_pkg::S_READ: begin
        ram_req.rd_en = 1'b1;
        state_next    = dofp_pkg::S_TAKE;
      end
      dofp_pkg::S_TAKE: begin
        if (val_done) begin
          load_val   = 1'b1;
          state_next = val_last ? dofp_pkg::S_RX : dofp_pkg::S_SEND;
        end else begin
          state_next = dofp_pkg::S_READ;
        end
      end
      dofp_pkg::S_SEND: begin
        if (out_xfer) begin
          state_next = dofp_pkg::S_READ;
        end
      end
      default: state_next = dofp_pkg::S_RX;
    endcase
  end

  // framing
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      byte_count <= '0;
    end else if (in_xfer) begin
      if (!frame_open) begin
        if (byte_in == start_marker) begin
          frame_open <= 1'b1;
          byte_count <= '0;
        end
      end else if (!closing) begin
        byte_count <= byte_count + 1'b1;
      end else begin
        frame_open <= 1'b0;
        byte_count <= '0;
      end
    end
  end

  // readout counters
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_float <= 1'b0;
      rd_addr    <= '0;
      val_idx    <= '0;
      byte_sel   <= '0;
    end else if (start_emit) begin
      emit_float <= (data_mode == dofp_pkg::MODE_FLOAT);
      rd_addr    <= '0;
      val_idx    <= '0;
      byte_sel   <= '0;
    end else if (state == dofp_pkg::S_TAKE) begin
      rd_addr <= rd_addr + 1'b1;
      if (val_done) begin
        val_idx  <= val_idx + 1'b1;
        byte_sel <= '0;
      end else begin
        byte_sel <= byte_sel + 1'b1;
      end
    end
  end

  // little-endian assembly, first byte ends up lowest
  always_ff @(posedge clk) begin
    if (state == dofp_pkg::S_TAKE) begin
      word <= {rd_data, word[dofp_pkg::VALUE_W-1:8]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_cmd || load_val) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      dof_index <= '0;
      dof_value <= '0;
      has_value <= 1'b0;
      last      <= 1'b1;
    end else if (load_val) begin
      dof_index <= val_idx;
      dof_value <= emit_float ? $signed({rd_data, word[dofp_pkg::VALUE_W-1:8]}) : mapped;
      has_value <= 1'b1;
      last      <= val_last;
    end
  end

  a_no_input_in_readout: assert property (@(posedge clk) disable iff (rst)
    (state != dofp_pkg::S_RX) |-> !in_ready)
    else $error("input taken during readout");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> (state == dofp_pkg::S_RX) && !ram_req.rd_en)
    else $error("buffer write overlaps readout");

  a_load_into_empty: assert property (@(posedge clk) disable iff (rst)
    (load_cmd || load_val) |-> !out_valid)
    else $error("result overwrites a pending result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= dofp_pkg::COUNT_W'(dofp_pkg::BUF_BYTES))
    else $error("payload count past buffer size");

  a_last_ends_readout: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (state == dofp_pkg::S_RX))
    else $error("readout continues after final result");

endmodule

/* hw/rtl/dofp_ram.sv */
// Frame payload buffer: one write port, one registered read port.
module dofp_ram (
  input  logic               clk,
  input  dofp_pkg::ram_req_t req,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [dofp_pkg::BUF_BYTES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* hw/rtl/dofp_map.sv */
// Maps a payload byte to b*28/255 - 14 in signed Q15.16, rounded to nearest.
module dofp_map (
  input  logic [7:0]                               byte_val,
  output logic signed [dofp_pkg::VALUE_W-1:0]      value
);

  logic [12:0] m;
  logic [4:0]  q0;
  logic [8:0]  r;
  logic [4:0]  q;
  logic [20:0] prod;

  // round(b*28/255) = floor((28b + 127) / 255), remainder kept below 2*255
  always_comb begin
    m    = 13'(byte_val * dofp_pkg::MAP_FRAC) + dofp_pkg::MAP_RND;
    q0   = m[12:8];
    r    = {1'b0, m[7:0]} + 9'(q0);
    q    = (r >= dofp_pkg::MAP_DIV) ? q0 + 5'd1 : q0;
    prod = 21'(byte_val * dofp_pkg::MAP_MUL);
    value = $signed({11'd0, prod}) + $signed({27'd0, q}) - dofp_pkg::MAP_OFFSET;
  end

endmodule
